/* hdl/dhce_pkg.sv */
// Shared types and constants for the dominant hue color extractor.
package dhce_pkg;

  localparam int unsigned LUMA_FULL = 2550000;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic        has_opaque;
    logic [15:0] mean_luminance;
    logic        has_dominant;
    logic [4:0]  dominant_bucket;
    logic [7:0]  dominant_red;
    logic [7:0]  dominant_green;
    logic [7:0]  dominant_blue;
  } result_t;

  localparam logic [1:0] REG_ALPHA_CUTOFF = 2'd0;
  localparam logic [1:0] REG_MIN_SAT      = 2'd1;
  localparam logic [1:0] REG_MIN_VALUE    = 2'd2;
  localparam logic [1:0] REG_MIN_CHROM    = 2'd3;

  // Bucket memory word: red, green, blue sums and weight sum.
  localparam int unsigned SUM_W  = 29;
  localparam int unsigned WSUM_W = 20;
  localparam int unsigned BUCKET_W = 3 * SUM_W + WSUM_W;

endpackage

/* hdl/dhce_ram.sv */
// Generic single write port, single read port RAM with registered read.
module dhce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/dhce_divider.sv */
// Restoring divider, one quotient bit per cycle.
module dhce_divider #(
  parameter int NW = 64,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);
  logic [NW-1:0]        q;
  logic [DW:0]          rem;
  logic [$clog2(NW+1)-1:0] cnt;
  logic [DW+1:0]        trial;

  assign trial = {rem, q[NW-1]} - {2'b00, den};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ($clog2(NW+1))'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == ($clog2(NW+1))'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW:0];
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-1:0], q[NW-1]};
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

/* hdl/dominant_hue_color_extractor_unit.sv */
// Top level of the dominant hue color extractor.
//
// Usage: pixels enter on the input channel (in_valid / in_stall / in_data),
// one item per cycle while the block accumulates. Each opaque pixel is
// classified; chromatic pixels update one hue bucket held in a RAM through
// a read-modify-write with forwarding, so a stream of pixels keeps one item
// per cycle. A pixel with last_pixel set closes the image: the block stalls
// its input, drains the pixel pipeline and runs a selection phase: luma mean
// division, a sweep of the buckets computing the ring scores, a fetch of the
// winner and its neighbors, and three channel divisions. The bucket RAM is
// then swept clear, one entry a cycle. One result item then appears on
// out_valid / out_data and holds until out_stall is low. A grey image skips
// the sweep, fetch and channel divisions.
// Reset clears the pixel counters, sets the configuration to its defaults,
// and runs a clearing pass over the bucket RAM before the first pixel is
// taken. Configuration writes (cfg_we, cfg_index, cfg_data) are taken any
// time but are meant for idle periods.
module dominant_hue_color_extractor_unit #(
  parameter int MAX_PIXELS  = 4096,
  parameter int HUE_BUCKETS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dhce_pkg::pixel_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dhce_pkg::result_t  out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  localparam int BW  = $clog2(HUE_BUCKETS);
  localparam int CW  = $clog2(MAX_PIXELS + 1);
  localparam int SW  = dhce_pkg::SUM_W;
  localparam int WW  = dhce_pkg::WSUM_W;
  localparam int MW  = dhce_pkg::BUCKET_W;
  localparam int LW  = 37;
  localparam int NW  = 64;
  localparam int DW  = 40;

  // sequencer codes
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_RUN    = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_LDIV   = 4'd3;
  localparam logic [3:0] S_SWEEP  = 4'd4;
  localparam logic [3:0] S_FETCH  = 4'd5;
  localparam logic [3:0] S_CDIV   = 4'd6;
  localparam logic [3:0] S_WIPE   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state;

  // configuration
  logic [7:0] alpha_cutoff;
  logic [6:0] min_sat, min_val, min_chrom;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_cutoff <= 8'd128;
      min_sat      <= 7'd18;
      min_val      <= 7'd15;
      min_chrom    <= 7'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dhce_pkg::REG_ALPHA_CUTOFF: alpha_cutoff <= cfg_data;
        dhce_pkg::REG_MIN_SAT:      min_sat      <= cfg_data[6:0];
        dhce_pkg::REG_MIN_VALUE:    min_val      <= cfg_data[6:0];
        dhce_pkg::REG_MIN_CHROM:    min_chrom    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------- pixel stage 1: classify ----------------
  logic        take;
  logic [7:0]  r, g, b, mx, mn, c;
  logic        opaque, chrom_ok;
  logic [14:0] sat_lhs, sat_rhs, val_lhs, val_rhs;
  logic [CW-1:0] opaque_count, chromatic_count;
  logic [LW-1:0] luma_sum;

  assign in_stall = (state != S_RUN);
  assign take = in_valid && !in_stall;
  assign r = in_data.red;
  assign g = in_data.green;
  assign b = in_data.blue;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    c = mx - mn;
    sat_lhs = 15'(c) * 15'd100;
    sat_rhs = 15'(min_sat) * 15'(mx);
    val_lhs = 15'(mx) * 15'd100;
    val_rhs = 15'(min_val) * 15'd255;
    opaque = (in_data.alpha >= alpha_cutoff) &&
             (opaque_count < CW'(MAX_PIXELS));
    chrom_ok = opaque && (c != 8'd0) && (sat_lhs >= sat_rhs) && (val_lhs >= val_rhs);
  end

  // hue numerator n in [0, 6c)
  logic [10:0] hn;
  always_comb begin
    if (r == mx) begin
      hn = (g >= b) ? 11'(g - b) : 11'(11'd6 * 11'(c) - 11'(b - g));
    end else if (g == mx) begin
      hn = 11'd2 * 11'(c) + 11'(b) - 11'(r);
    end else begin
      hn = 11'd4 * 11'(c) + 11'(r) - 11'(g);
    end
  end

  // stage 1 registers
  logic          p1_valid, p1_last;
  logic [10:0]   p1_hn;
  logic [7:0]    p1_r, p1_g, p1_b, p1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= take && chrom_ok;
    end
    p1_hn <= hn;
    p1_r <= r;
    p1_g <= g;
    p1_b <= b;
    p1_c <= c;
  end

  // ---------------- pixel stage 2: bucket index ----------------
  // k = floor(n*BUCKETS / (6c)): compare against multiples, few dependent steps
  logic [BW-1:0] k1;
  logic [16:0]   nk, six_c;
  always_comb begin
    nk = 17'(p1_hn) * 17'(HUE_BUCKETS);
    six_c = 17'(p1_c) * 17'd6;
    k1 = '0;
    for (int j = 1; j < HUE_BUCKETS; j++) begin
      if (nk >= 17'(six_c * 17'(j))) k1 = BW'(j);
    end
  end

  logic          p2_valid;
  logic [BW-1:0] p2_k;
  logic [7:0]    p2_c;
  logic [15:0]   p2_rc, p2_gc, p2_bc;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_k  <= k1;
    p2_c  <= p1_c;
    p2_rc <= 16'(p1_r) * 16'(p1_c);
    p2_gc <= 16'(p1_g) * 16'(p1_c);
    p2_bc <= 16'(p1_b) * 16'(p1_c);
  end

  // ---------------- pixel stage 3: read-modify-write ----------------
  logic          ram_we;
  logic [BW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  logic          p3_valid;
  logic [BW-1:0] p3_k;
  logic [7:0]    p3_c;
  logic [15:0]   p3_rc, p3_gc, p3_bc;
  logic          wb_valid;
  logic [BW-1:0] wb_k;
  logic [MW-1:0] wb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
      wb_valid <= p3_valid;
    end
    p3_k  <= p2_k;
    p3_c  <= p2_c;
    p3_rc <= p2_rc;
    p3_gc <= p2_gc;
    p3_bc <= p2_bc;
    wb_k  <= p3_k;
    wb_data <= ram_wdata;
  end

  // forward the entry written last cycle when it is read again
  logic [MW-1:0] old_word;
  logic [SW-1:0] o_r, o_g, o_b;
  logic [WW-1:0] o_w;
  assign old_word = (wb_valid && wb_k == p3_k) ? wb_data : ram_rdata;
  assign {o_r, o_g, o_b, o_w} = old_word;

  // ---------------- selection phase ----------------
  logic [BW:0]    idx;
  logic [WW+1:0]  best_score, score;
  logic [BW-1:0]  best_k;
  logic [SW+1:0]  acc_r, acc_g, acc_b;
  logic [1:0]     fetch_n;
  logic [1:0]     ch;
  logic [2:0]     drain;

  logic           div_start, div_busy;
  logic [NW-1:0]  div_num, div_quot;
  logic [DW-1:0]  div_den;
  logic           div_go;

  dhce_divider #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quot(div_quot)
  );

  dhce_pkg::result_t res;
  logic grey;

  // ring index helpers
  function automatic logic [BW-1:0] wrap_prev(input logic [BW-1:0] i);
    return (i == '0) ? BW'(HUE_BUCKETS - 1) : i - 1'b1;
  endfunction
  function automatic logic [BW-1:0] wrap_next(input logic [BW-1:0] i);
    return (i == BW'(HUE_BUCKETS - 1)) ? '0 : i + 1'b1;
  endfunction

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p3_k;
    ram_wdata = {o_r + SW'(p3_rc), o_g + SW'(p3_gc), o_b + SW'(p3_bc), o_w + WW'(p3_c)};
    ram_raddr = p2_k;
    if (state == S_CLEAR || state == S_WIPE) begin
      ram_we    = 1'b1;
      ram_waddr = idx[BW-1:0];
      ram_wdata = '0;
    end else if (p3_valid) begin
      ram_we = 1'b1;
    end
    if (state == S_SWEEP) begin
      // read order: last bucket, then 0..BUCKETS-1, then 0 again
      if (idx == '0) ram_raddr = BW'(HUE_BUCKETS - 1);
      else if (idx > (BW+1)'(HUE_BUCKETS)) ram_raddr = '0;
      else ram_raddr = BW'(idx - 1'b1);
    end else if (state == S_FETCH) begin
      unique case (fetch_n)
        2'd0: ram_raddr = wrap_prev(best_k);
        2'd1: ram_raddr = best_k;
        default: ram_raddr = wrap_next(best_k);
      endcase
    end
  end

  // sweep window: keep the two previous weights; the score adds the current one
  logic [WW-1:0] wa, wb;
  assign score = {2'b00, wa} + {1'b0, wb, 1'b0} + (WW+2)'(o_w);

  logic [SW+1:0] acc_add_r, acc_add_g, acc_add_b;
  assign acc_add_r = (fetch_n == 2'd2) ? {1'b0, o_r, 1'b0} : {2'b00, o_r};
  assign acc_add_g = (fetch_n == 2'd2) ? {1'b0, o_g, 1'b0} : {2'b00, o_g};
  assign acc_add_b = (fetch_n == 2'd2) ? {1'b0, o_b, 1'b0} : {2'b00, o_b};

  // grey test
  logic [19:0] chrom_lhs, chrom_rhs;
  assign chrom_lhs = 20'(chromatic_count) * 20'd100;
  assign chrom_rhs = 20'(min_chrom) * 20'(opaque_count);
  assign grey = chrom_lhs < chrom_rhs;

  logic [36:0] luma_pix;
  assign luma_pix = 37'(21'(r) * 21'd2126) + 37'(21'(g) * 21'd7152) +
                    37'(21'(b) * 21'd722);

  logic [DW-1:0] luma_den;
  assign luma_den = DW'(dhce_pkg::LUMA_FULL) * DW'(opaque_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      opaque_count    <= '0;
      chromatic_count <= '0;
      luma_sum  <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      drain     <= '0;
      res       <= '0;
    end else begin
      unique case (state)
        S_CLEAR, S_WIPE: begin
          if (idx == (BW+1)'(HUE_BUCKETS - 1)) begin
            idx <= '0;
            if (state == S_WIPE) begin
              state <= S_OUT;
              out_valid <= 1'b1;
            end else begin
              state <= S_RUN;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RUN: begin
          if (take) begin
            if (in_data.alpha >= alpha_cutoff && opaque_count < CW'(MAX_PIXELS)) begin
              opaque_count <= opaque_count + 1'b1;
              luma_sum <= luma_sum + luma_pix;
            end
            if (chrom_ok) chromatic_count <= chromatic_count + 1'b1;
            if (in_data.last_pixel) begin
              state <= S_DRAIN;
              drain <= 3'd4;
            end
          end
        end
        S_DRAIN: begin
          drain <= drain - 1'b1;
          if (drain == 3'd1) begin
            if (opaque_count == '0) begin
              idx   <= '0;
              state <= S_WIPE;
            end else begin
              res.has_opaque <= 1'b1;
              div_num   <= NW'({luma_sum[LW-1:0], 16'd0, 1'b0}) + NW'(luma_den);
              div_den   <= {luma_den[DW-2:0], 1'b0};
              div_start <= 1'b1;
              div_go    <= 1'b1;
              state     <= S_LDIV;
            end
          end
        end
        S_LDIV: begin
          if (div_go) begin
            div_go    <= 1'b0;
            div_start <= 1'b0;
          end else if (!div_busy) begin
            res.mean_luminance <= (div_quot > NW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
            if (grey) begin
              idx <= '0;
              state <= S_WIPE;
            end else begin
              idx <= '0;
              best_score <= '0;
              best_k <= '0;
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          // data for read issued at idx-1 arrives now
          if (idx != '0) begin
            wa <= wb;
            wb <= o_w;
            if (idx >= (BW+1)'(3) && score > best_score) begin
              best_score <= score;
              best_k <= BW'(idx - (BW+1)'(3));
            end
          end
          if (idx == (BW+1)'(HUE_BUCKETS + 2)) begin
            idx <= '0;
            if (score > best_score || best_score != '0) begin
              state <= S_FETCH;
              fetch_n <= '0;
              acc_r <= '0;
              acc_g <= '0;
              acc_b <= '0;
            end else begin
              state <= S_WIPE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FETCH: begin
          idx <= idx + 1'b1;
          if (idx != '0) begin
            acc_r <= acc_r + acc_add_r;
            acc_g <= acc_g + acc_add_g;
            acc_b <= acc_b + acc_add_b;
          end
          if (idx < (BW+1)'(3)) fetch_n <= fetch_n + 1'b1;
          if (idx == (BW+1)'(3)) begin
            res.has_dominant <= 1'b1;
            res.dominant_bucket <= 5'(best_k);
            ch <= 2'd0;
            div_go <= 1'b1;
            state <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (div_go) begin
            div_go    <= 1'b0;
            div_start <= 1'b1;
            div_den   <= DW'({best_score, 1'b0});
            unique case (ch)
              2'd0: div_num <= NW'({acc_r, 1'b0}) + NW'(best_score);
              2'd1: div_num <= NW'({acc_g, 1'b0}) + NW'(best_score);
              default: div_num <= NW'({acc_b, 1'b0}) + NW'(best_score);
            endcase
          end else if (div_start) begin
            div_start <= 1'b0;
          end else if (!div_busy) begin
            unique case (ch)
              2'd0: res.dominant_red <= div_quot[7:0];
              2'd1: res.dominant_green <= div_quot[7:0];
              default: res.dominant_blue <= div_quot[7:0];
            endcase
            if (ch == 2'd2) begin
              idx <= '0;
              state <= S_WIPE;
            end else begin
              ch <= ch + 1'b1;
              div_go <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            res <= '0;
            opaque_count <= '0;
            chromatic_count <= '0;
            luma_sum <= '0;
            state <= S_RUN;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign out_data = res;

  dhce_ram #(.WIDTH(MW), .DEPTH(HUE_BUCKETS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
endmodule

/* hdl/dhce_checker.sv */
// Port-level assertions for the dominant hue color extractor, bound to the top level.
module dhce_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input dhce_pkg::result_t out_data
);
  // a result without opaque pixels carries no luminance and no dominant color
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.has_opaque |-> out_data.mean_luminance == 16'd0 &&
      !out_data.has_dominant) else $error("empty result carries data");

  // no dominant color without opaque pixels
  a_dom: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.has_dominant |-> out_data.has_opaque)
    else $error("dominant without opaque");

  // bucket index in range
  a_bucket: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.dominant_bucket < 5'd24) else $error("bucket out of range");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

  // no pixel is taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
endmodule

bind dominant_hue_color_extractor_unit dhce_checker u_dhce_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
